>>> src/kepler_equation_bisection_solver_defines.svh
// Assertion helpers for the solver control module.
`ifndef KEPLER_EQUATION_BISECTION_SOLVER_DEFINES_SVH
`define KEPLER_EQUATION_BISECTION_SOLVER_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define KEBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kebs check failed");

// Clocked check that also holds during reset.
`define KEBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kebs check failed");

`endif

>>> src/kebs_pkg.sv
// ----------------------------------------------------------------------------
// kebs_pkg
// Types, register indexes and fixed constants of the Kepler bisection solver.
// ----------------------------------------------------------------------------
package kebs_pkg;

  localparam int unsigned AngleW = 32;   // Q3.29 angle
  localparam int unsigned EccW   = 31;   // Q1.30 eccentricity
  localparam int unsigned TolW   = 31;
  localparam int unsigned IterW  = 10;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] RegEcc  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegTol  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegIter = 8'd2;

  localparam logic [TolW-1:0]  TolReset  = 31'd54;
  localparam logic [IterW-1:0] IterReset = 10'd1000;

  localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] SinOne     = 34'sd1073741824;

  typedef struct packed {
    logic load;   // take a new mean anomaly, open the bracket
    logic prep;   // pick the angle, reduce it, seed the rotator
    logic init;   // angle is the lower bound, not a midpoint
    logic rot;    // one rotation step
    logic mul;    // e * |sin|
    logic res;    // residual sign
    logic eval;   // move a bound
  } kebs_cmd_t;

  typedef struct packed {
    logic step_last;
    logic lt_tol;
    logic cap_hit;
  } kebs_status_t;

  function automatic logic signed [35:0] atan_q30(input int unsigned k);
    logic signed [35:0] v;
    case (k)
      0:  v = 36'sd843314856;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043836;
      3:  v = 36'sd133525158;
      4:  v = 36'sd67021686;
      5:  v = 36'sd33543515;
      6:  v = 36'sd16775850;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194282;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048575;
      default: begin
        if (k <= 30) v = 36'((longint'(1) << (30 - k)) - 1);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

>>> src/kepler_equation_bisection_solver.sv
// ----------------------------------------------------------------------------
// kepler_equation_bisection_solver
// Solves E - e*sin(E) = M by bisection over [0, 8] rad with a CORDIC sine.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// command   in         start & !busy              mean_anomaly_i
// result    out        done_o (one-cycle strobe)  eccentric_anomaly_o,
//                                                 iteration_count_o, hit_limit_o
// config    in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item is solved at a time; every residual evaluation, one per halving plus
// one for the lower bound, runs on the single shared CORDIC rotator.
// Each halving evaluates the residual at the midpoint only; the lower-bound
// sign is kept from the previous step. Reset is asynchronous, active low.
// cfg_ready_o is always high. The receiver cannot stall results.
module kepler_equation_bisection_solver import kebs_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [AngleW-1:0]  mean_anomaly_i,
  output logic               done_o,
  output logic [AngleW-1:0]  eccentric_anomaly_o,
  output logic [IterW-1:0]   iteration_count_o,
  output logic               hit_limit_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  kebs_cmd_t    cmd;
  kebs_status_t status;

  assign cfg_ready_o = 1'b1;

  kebs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .status_i    (status),
    .cmd_o       (cmd),
    .done_o      (done_o),
    .hit_limit_o (hit_limit_o)
  );

  kebs_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .mean_anomaly_i      (mean_anomaly_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .eccentric_anomaly_o (eccentric_anomaly_o),
    .iteration_count_o   (iteration_count_o)
  );

endmodule

>>> src/kebs_datapath.sv
// ----------------------------------------------------------------------------
// kebs_datapath
// Bracket registers, configuration, shared CORDIC sine and residual sign.
// ----------------------------------------------------------------------------
module kebs_datapath import kebs_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  input  logic [AngleW-1:0]   mean_anomaly_i,
  input  kebs_cmd_t           cmd_i,
  output kebs_status_t        status_o,
  output logic [AngleW-1:0]   eccentric_anomaly_o,
  output logic [IterW-1:0]    iteration_count_o
);

  localparam int unsigned KW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic [EccW-1:0]  ecc_q;
  logic [TolW-1:0]  tol_q;
  logic [IterW-1:0] iter_q;

  logic [AngleW-1:0] mean_q;
  logic [AngleW:0]   lo_q, hi_q, mid_q, ang_q;
  logic [IterW-1:0]  cnt_q;
  logic signed [33:0] x_q, y_q;
  logic signed [35:0] z_q;
  logic [KW-1:0]      k_q;
  logic [61:0]        prod_q;
  logic               sneg_q;
  logic               fz_q, fn_q, flz_q, fln_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q  <= '0;
      tol_q  <= TolReset;
      iter_q <= IterReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegEcc:  ecc_q  <= cfg_data_i[EccW-1:0];
        RegTol:  tol_q  <= cfg_data_i[TolW-1:0];
        RegIter: iter_q <= cfg_data_i[IterW-1:0];
        default: ;
      endcase
    end
  end

  // angle selection and range reduction into [-pi/2, pi/2]
  logic [AngleW:0]    sum_w, ang_d;
  logic signed [35:0] th0, th1, th2, th3;
  always_comb begin
    sum_w = 33'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
    ang_d = cmd_i.init ? lo_q : sum_w;
    th0   = 36'({ang_d, 1'b0});
    th1   = (th0 >= Q30TwoPi) ? th0 - Q30TwoPi : th0;
    th2   = (th1 > Q30Pi) ? th1 - Q30TwoPi : th1;
    if (th2 > Q30HalfPi) th3 = Q30Pi - th2;
    else if (th2 < -Q30HalfPi) th3 = -Q30Pi - th2;
    else th3 = th2;
  end

  // rotation step
  logic signed [33:0] dx, dy;
  logic signed [35:0] at;
  always_comb begin
    dx = y_q >>> k_q;
    dy = x_q >>> k_q;
    at = atan_q30(int'(k_q));
  end

  // clamp, magnitude
  logic signed [33:0] ys;
  logic [30:0]        mag;
  always_comb begin
    if (y_q > SinOne) ys = SinOne;
    else if (y_q < -SinOne) ys = -SinOne;
    else ys = y_q;
    mag = ys[33] ? 31'(-ys) : 31'(ys);
  end

  // residual f = angle - e*sin - mean
  logic [62:0]        rsum;
  logic [31:0]        rnd;
  logic signed [35:0] es, f;
  always_comb begin
    rsum = {1'b0, prod_q} + 63'(64'd1 << 30);
    rnd  = rsum[62:31];
    es   = sneg_q ? -36'(rnd) : 36'(rnd);
    f    = 36'(ang_q) - es - 36'(mean_q);
  end

  logic move_hi;
  assign move_hi = fz_q || flz_q || (fn_q != fln_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mean_q <= mean_anomaly_i;
      lo_q   <= '0;
      hi_q   <= 33'(64'd1 << AngleW);
    end
    if (cmd_i.prep) begin
      ang_q <= ang_d;
      if (!cmd_i.init) mid_q <= ang_d;
      z_q   <= th3;
      x_q   <= CordicGain;
      y_q   <= '0;
      k_q   <= '0;
    end
    if (cmd_i.rot) begin
      if (!z_q[35]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= 62'(ecc_q) * 62'(mag);
      sneg_q <= ys[33];
    end
    if (cmd_i.res) begin
      fz_q <= (f == '0);
      fn_q <= f[35];
    end
    if (cmd_i.eval) begin
      if (cmd_i.init) begin
        flz_q <= fz_q;
        fln_q <= fn_q;
      end else if (move_hi) begin
        hi_q <= mid_q;
      end else begin
        lo_q  <= mid_q;
        flz_q <= fz_q;
        fln_q <= fn_q;
      end
    end
  end

  // halving counter is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.prep && !cmd_i.init) begin
      cnt_q <= cnt_q + IterW'(1);
    end
  end

  logic [IterW-1:0] cap;
  assign cap = (iter_q == '0) ? IterW'(1) : iter_q;

  assign status_o.step_last = (k_q == KW'(CORDIC_STEPS - 1));
  assign status_o.lt_tol    = ((hi_q - lo_q) < 33'(tol_q));
  assign status_o.cap_hit   = (cnt_q >= cap);

  assign eccentric_anomaly_o = mid_q[AngleW-1:0];
  assign iteration_count_o   = cnt_q;

endmodule

>>> src/kebs_ctrl.sv
// ----------------------------------------------------------------------------
// kebs_ctrl
// Sequencer: seed, rotate, multiply, residual, bound update, stop test.
// ----------------------------------------------------------------------------
`include "kepler_equation_bisection_solver_defines.svh"

module kebs_ctrl import kebs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  kebs_status_t status_i,
  output kebs_cmd_t    cmd_o,
  output logic         done_o,
  output logic         hit_limit_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_ROT, S_MUL, S_RES, S_EVAL, S_CHECK, S_DONE
  } state_e;

  state_e state_q;
  logic   init_q, done_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            init_q  <= 1'b1;
            state_q <= S_PREP;
          end
        end
        S_PREP: state_q <= S_ROT;
        S_ROT: begin
          if (status_i.step_last) state_q <= S_MUL;
        end
        S_MUL: state_q <= S_RES;
        S_RES: state_q <= S_EVAL;
        S_EVAL: begin
          init_q  <= 1'b0;
          state_q <= init_q ? S_PREP : S_CHECK;
        end
        S_CHECK: begin
          if (status_i.lt_tol) begin
            hit_q   <= 1'b0;
            done_q  <= 1'b1;
            state_q <= S_DONE;
          end else if (status_i.cap_hit) begin
            hit_q   <= 1'b1;
            done_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_PREP;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.init = init_q;
    cmd_o.load = (state_q == S_IDLE) && start;
    cmd_o.prep = (state_q == S_PREP);
    cmd_o.rot  = (state_q == S_ROT);
    cmd_o.mul  = (state_q == S_MUL);
    cmd_o.res  = (state_q == S_RES);
    cmd_o.eval = (state_q == S_EVAL);
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign hit_limit_o = hit_q;

  `KEBS_ASSERT(a_done_then_idle, clk_i, rst_ni, done_o |=> !busy)
  `KEBS_ASSERT(a_hit_means_cap, clk_i, rst_ni, done_o && hit_limit_o |-> status_i.cap_hit)
  `KEBS_ASSERT(a_conv_means_tol, clk_i, rst_ni, done_o && !hit_limit_o |-> status_i.lt_tol)
  `KEBS_ASSERT_ALWAYS(a_done_while_busy, clk_i, done_o |-> busy)

endmodule

>>> verif/tb_kepler_equation_bisection_solver.sv
// ----------------------------------------------------------------------------
// tb_kepler_equation_bisection_solver
// Self-checking bench for the bisection Kepler solver. A directed table covers
// the register extremes, the iteration cap and tolerance corner cases. Random
// mean anomalies then follow under changing register settings and sender
// idling. Each result is compared with a typed expectation or a bit-exact model.
// ----------------------------------------------------------------------------
module tb_kepler_equation_bisection_solver;
  import kebs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MaxCycles = 20_000_000;

  typedef struct {
    logic [AngleW-1:0] anomaly;
    logic [IterW-1:0]  halvings;
    logic              capped;
  } solution_t;

  typedef struct {
    logic [CfgDatW-1:0] ecc;
    logic [CfgDatW-1:0] tol;
    logic [CfgDatW-1:0] cap;
    logic [AngleW-1:0]  mean;
    bit                 typed;
    solution_t          sol;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [AngleW-1:0]  mean_anomaly_i = '0;
  logic               done_o;
  logic [AngleW-1:0]  eccentric_anomaly_o;
  logic [IterW-1:0]   iteration_count_o;
  logic               hit_limit_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  kepler_equation_bisection_solver dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register shadow of the solver.
  longint unsigned ecc_q30, tol_lsb, iter_cap;
  solution_t       pending_q[$];
  int              mismatches = 0;
  int              sender_idle_pct = 0;
  longint unsigned cycle_cnt = 0;

  // atan(2^-k) in Q.30, truncated.
  function automatic longint atan_step(int k);
    longint head [11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
    if (k < 11) return head[k];
    if (k <= 30) return (longint'(1) << (30 - k)) - 1;
    return 0;
  endfunction

  function automatic longint cordic_sin(longint theta);
    longint cx, cy, dx, dy;
    cx = 652032874;
    cy = 0;
    while (theta >= 64'sd6746518852) theta -= 64'sd6746518852;
    if (theta > 64'sd3373259426) theta -= 64'sd6746518852;
    if (theta > 64'sd1686629713) theta = 64'sd3373259426 - theta;
    else if (theta < -64'sd1686629713) theta = -64'sd3373259426 - theta;
    for (int k = 0; k < 32; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (theta >= 0) begin
        cx -= dx; cy += dy; theta -= atan_step(k);
      end else begin
        cx += dx; cy -= dy; theta += atan_step(k);
      end
    end
    if (cy > (longint'(1) << 30)) cy = longint'(1) << 30;
    if (cy < -(longint'(1) << 30)) cy = -(longint'(1) << 30);
    return cy;
  endfunction

  // E - e*sin(E) - M, with e*sin rounded half away from zero to Q3.29.
  function automatic longint kepler_residual(longint unsigned ang, longint unsigned mean);
    longint          sn;
    longint unsigned mag, rnd;
    sn  = cordic_sin(longint'(ang << 1));
    mag = (sn < 0) ? longint'(-sn) : longint'(sn);
    rnd = (ecc_q30 * mag + (64'd1 << 30)) >> 31;
    if (sn < 0) return longint'(ang) + longint'(rnd) - longint'(mean);
    return longint'(ang) - longint'(rnd) - longint'(mean);
  endfunction

  function automatic solution_t solve_kepler(logic [AngleW-1:0] mean);
    longint unsigned lo, hi, mid, cap, cnt;
    longint          fm, fl;
    solution_t       s;
    lo  = 0;
    hi  = 64'd1 << AngleW;
    mid = 64'd1 << (AngleW - 1);
    cap = (iter_cap == 0) ? 64'd1 : iter_cap;
    cnt = 0;
    s.capped = 1'b0;
    while (!(hi - lo < tol_lsb)) begin
      cnt++;
      mid = (lo + hi) >> 1;
      fm  = kepler_residual(mid, 64'(mean));
      fl  = kepler_residual(lo, 64'(mean));
      if (fm == 0 || fl == 0 || ((fm < 0) != (fl < 0))) hi = mid;
      else lo = mid;
      if (hi - lo < tol_lsb) break;
      if (cnt >= cap) begin
        s.capped = 1'b1;
        break;
      end
    end
    s.anomaly  = mid[AngleW-1:0];
    s.halvings = cnt[IterW-1:0];
    return s;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegEcc:  ecc_q30  = 64'(data[EccW-1:0]);
      RegTol:  tol_lsb  = 64'(data[TolW-1:0]);
      RegIter: iter_cap = 64'(data[IterW-1:0]);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all results, then let the block settle before touching registers.
  task automatic drain();
    while (pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic issue(logic [AngleW-1:0] mean, bit typed, solution_t sol);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    mean_anomaly_i <= mean;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(typed ? sol : solve_kepler(mean));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result E=%h", eccentric_anomaly_o);
      end else begin
        solution_t s;
        s = pending_q.pop_front();
        if (s.anomaly !== eccentric_anomaly_o || s.halvings !== iteration_count_o ||
            s.capped !== hit_limit_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp E=%h n=%0d cap=%b, got E=%h n=%0d cap=%b",
                     s.anomaly, s.halvings, s.capped, eccentric_anomaly_o,
                     iteration_count_o, hit_limit_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= MaxCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  dir_row_t dir_rows [12] = '{
    // reset settings at both ends of the mean anomaly, then the largest eccentricity
    '{32'd0, 32'd54, 32'd1000, 32'h0000_0000, 1'b0, '{'0, '0, 1'b0}},
    '{32'd0, 32'd54, 32'd1000, 32'hFFFF_FFFF, 1'b0, '{'0, '0, 1'b0}},
    '{32'h7FFF_FFFF, 32'd54, 32'd1000, 32'h8000_0000, 1'b0, '{'0, '0, 1'b0}},
    '{32'hFFFF_FFFF, 32'd54, 32'd1000, 32'h5555_5555, 1'b0, '{'0, '0, 1'b0}},
    // single halving: midpoint 4.0 and the cap fires
    '{32'h4000_0000, 32'd1, 32'd1, 32'h1234_5678, 1'b1, '{32'h8000_0000, 10'd1, 1'b1}},
    // zero cap behaves like one
    '{32'h4000_0000, 32'd1, 32'd0, 32'hEDCB_A987, 1'b1, '{32'h8000_0000, 10'd1, 1'b1}},
    // zero tolerance never converges
    '{32'h2000_0000, 32'd0, 32'd5, 32'h3000_0000, 1'b1, '{'0, 10'd5, 1'b1}},
    // widest tolerance, converges on the capping halving
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd2, 32'hAAAA_AAAA, 1'b0, '{'0, '0, 1'b0}},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1023, 32'h0000_0001, 1'b0, '{'0, '0, 1'b0}},
    // unit tolerance: bracket stalls at width one, full cap
    '{32'h1000_0000, 32'd1, 32'd1023, 32'h2468_ACE0, 1'b0, '{'0, '0, 1'b0}},
    // roots near the upper and the lower end, eccentric orbit
    '{32'h3FFF_FFFF, 32'd54, 32'd1000, 32'hFFFF_FF00, 1'b0, '{'0, '0, 1'b0}},
    '{32'h3FFF_FFFF, 32'd54, 32'd1000, 32'h0000_0100, 1'b0, '{'0, '0, 1'b0}}
  };

  initial begin
    solution_t none;
    logic [CfgDatW-1:0] tol_pick;
    ecc_q30  = 0;
    tol_lsb  = 64'(TolReset);
    iter_cap = 64'(IterReset);
    none = '{'0, '0, 1'b0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        // the typed midpoint of the zero-tolerance row is taken from the model
        if (dir_rows[i].sol.anomaly == '0) dir_rows[i].typed = 1'b0;
      end
      if (64'(dir_rows[i].ecc[EccW-1:0]) != ecc_q30 ||
          64'(dir_rows[i].tol[TolW-1:0]) != tol_lsb ||
          64'(dir_rows[i].cap[IterW-1:0]) != iter_cap) begin
        start <= 1'b0;
        drain();
        write_reg(RegEcc, dir_rows[i].ecc);
        write_reg(RegTol, dir_rows[i].tol);
        write_reg(RegIter, dir_rows[i].cap);
      end
      issue(dir_rows[i].mean, dir_rows[i].typed, dir_rows[i].sol);
    end

    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph < 4) ? 15 : (ph < 8) ? 83 : 0;
      start <= 1'b0;
      drain();
      write_reg(RegEcc, (ph % 4 == 3) ? 32'hFFFF_FFFF : $urandom());
      case ($urandom_range(3))
        0: tol_pick = TolReset;
        1: tol_pick = $urandom_range(1, 32'h000F_FFFF);
        2: tol_pick = 32'({$urandom_range(1), $urandom()} >> 1);
        default: tol_pick = $urandom_range(1, 2000);
      endcase
      write_reg(RegTol, tol_pick);
      write_reg(RegIter, (ph % 4 == 2) ? 32'd1 : 32'($urandom_range(1, 40)));
      for (int n = 0; n < 54; n++) issue($urandom(), 1'b0, none);
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
